@@ hdl/spq_pkg.sv @@
`timescale 1ns / 1ps

package spq_pkg;

    localparam int ID_W     = 5;
    localparam int PRIO_W   = 8;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 6;

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_PEEK   = 2'd1,
        MODE_POP    = 2'd2,
        MODE_REMOVE = 2'd3
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    typedef struct packed {
        logic ins_en;
        logic pop_en;
        logic rem_en;
    } t_cell_ctrl;

endpackage

@@ hdl/stable_priority_process_queue.sv @@
`timescale 1ns / 1ps
// Sorted ready queue of process ids, highest priority first, FIFO among equals.
// Command channel: drive i_mode, i_proc_id, i_priority_req with start high;
// the word is taken at a rising edge where start is high and busy is low.
// Modes: insert, peek head, pop head, remove by id.
// Storage is a row of DEPTH cells; every cell compares its entry with the
// command word and loads from its left or right neighbor or the command word, so
// an insert or delete shifts the whole row at once.
// The result is registered as the busy cycle ends and appears on the o_ ports,
// marked by o_done for exactly one cycle. busy is high for the one cycle in
// which the cell row updates, so no new word is accepted until that update
// pass through the cell row is done.
// The result is not held: the receiver must take it in the o_done cycle.
// Reset (i_rst_n low, synchronous) empties the queue and clears any pending
// command; entry contents are not cleared, only the cell valid flags.
module stable_priority_process_queue #(
    parameter int DEPTH     = 32,
    parameter int PRIO_BITS = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   i_mode,
    input  logic [spq_pkg::ID_W-1:0]     i_proc_id,
    input  logic [spq_pkg::PRIO_W-1:0]   i_priority_req,
    output logic                         o_done,
    output logic [spq_pkg::STATUS_W-1:0] o_status,
    output logic [spq_pkg::ID_W-1:0]     o_result_id,
    output logic [spq_pkg::PRIO_W-1:0]   o_result_priority,
    output logic [spq_pkg::COUNT_W-1:0]  o_entry_count
);
    import spq_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    logic                 r_pend;
    t_mode                r_mode;
    logic [ID_W-1:0]      r_pid;
    logic [PRIO_BITS-1:0] r_prio;
    logic [CW-1:0]        r_count;
    logic [CW-1:0]        n_count;

    logic                 r_done;
    t_status              r_status;
    t_status              n_status;
    logic [ID_W-1:0]      r_res_id;
    logic [ID_W-1:0]      n_res_id;
    logic [PRIO_BITS-1:0] r_res_prio;
    logic [PRIO_BITS-1:0] n_res_prio;

    logic [ID_W-1:0]      w_id    [DEPTH];
    logic [PRIO_BITS-1:0] w_prio  [DEPTH];
    logic                 w_valid [DEPTH];
    logic                 w_ins   [DEPTH];
    logic                 w_found [DEPTH];
    logic                 w_hit   [DEPTH];

    logic                 w_full;
    logic                 w_empty;
    logic                 w_any;
    logic [PRIO_BITS-1:0] w_hit_prio;
    t_cell_ctrl           w_ctrl;

    assign busy              = r_pend;
    assign o_done            = r_done;
    assign o_status          = r_status;
    assign o_result_id       = r_res_id;
    assign o_result_priority = PRIO_W'(r_res_prio);
    assign o_entry_count     = COUNT_W'(r_count);

    assign w_full  = (r_count == CW'(DEPTH));
    assign w_empty = (r_count == '0);
    assign w_any   = w_found[DEPTH-1];

    assign w_ctrl.ins_en = r_pend && (r_mode == MODE_INSERT) && !w_full;
    assign w_ctrl.pop_en = r_pend && (r_mode == MODE_POP) && !w_empty;
    assign w_ctrl.rem_en = r_pend && (r_mode == MODE_REMOVE) && w_any;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            logic [ID_W-1:0]      l_id;
            logic [PRIO_BITS-1:0] l_prio;
            logic                 l_valid;
            logic                 l_ins;
            logic [ID_W-1:0]      rt_id;
            logic [PRIO_BITS-1:0] rt_prio;
            logic                 rt_valid;
            logic                 l_found;

            if (g == 0) begin : g_head
                assign l_id    = '0;
                assign l_prio  = '0;
                assign l_valid = 1'b0;
                assign l_ins   = 1'b0;
                assign l_found = 1'b0;
            end else begin : g_body
                assign l_id    = w_id[g-1];
                assign l_prio  = w_prio[g-1];
                assign l_valid = w_valid[g-1];
                assign l_ins   = w_ins[g-1];
                assign l_found = w_found[g-1];
            end

            if (g == DEPTH - 1) begin : g_tail
                assign rt_id    = '0;
                assign rt_prio  = '0;
                assign rt_valid = 1'b0;
            end else begin : g_inner
                assign rt_id    = w_id[g+1];
                assign rt_prio  = w_prio[g+1];
                assign rt_valid = w_valid[g+1];
            end

            spq_cell #(
                .PRIO_BITS(PRIO_BITS)
            ) u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctrl       (w_ctrl),
                .i_pid        (r_pid),
                .i_prio       (r_prio),
                .i_left_id    (l_id),
                .i_left_prio  (l_prio),
                .i_left_valid (l_valid),
                .i_left_ins   (l_ins),
                .i_right_id   (rt_id),
                .i_right_prio (rt_prio),
                .i_right_valid(rt_valid),
                .i_found      (l_found),
                .o_id         (w_id[g]),
                .o_prio       (w_prio[g]),
                .o_valid      (w_valid[g]),
                .o_ins        (w_ins[g]),
                .o_found      (w_found[g]),
                .o_hit        (w_hit[g])
            );
        end
    endgenerate

    always_comb begin
        w_hit_prio = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (w_hit[i]) begin
                w_hit_prio = w_hit_prio | w_prio[i];
            end
        end
    end

    always_comb begin
        n_status   = ST_OK;
        n_res_id   = '0;
        n_res_prio = '0;
        n_count    = r_count;
        unique case (r_mode)
            MODE_INSERT: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_res_id   = r_pid;
                    n_res_prio = r_prio;
                    n_count    = r_count + CW'(1);
                end
            end
            MODE_PEEK, MODE_POP: begin
                if (w_empty) begin
                    n_status = ST_MISS;
                end else begin
                    n_res_id   = w_id[0];
                    n_res_prio = w_prio[0];
                    if (r_mode == MODE_POP) begin
                        n_count = r_count - CW'(1);
                    end
                end
            end
            MODE_REMOVE: begin
                if (!w_any) begin
                    n_status = ST_MISS;
                end else begin
                    n_res_id   = r_pid;
                    n_res_prio = w_hit_prio;
                    n_count    = r_count - CW'(1);
                end
            end
            default: begin
                n_status = ST_MISS;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend  <= 1'b0;
            r_done  <= 1'b0;
            r_count <= '0;
        end else begin
            r_done <= r_pend;
            if (r_pend) begin
                r_pend  <= 1'b0;
                r_count <= n_count;
            end else if (start) begin
                r_pend <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !r_pend) begin
            r_mode <= t_mode'(i_mode);
            r_pid  <= i_proc_id;
            r_prio <= PRIO_BITS'(i_priority_req);
        end
        if (r_pend) begin
            r_status   <= n_status;
            r_res_id   <= n_res_id;
            r_res_prio <= n_res_prio;
        end
    end

endmodule

@@ hdl/spq_cell.sv @@
`timescale 1ns / 1ps

module spq_cell #(
    parameter int PRIO_BITS = 8
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  spq_pkg::t_cell_ctrl      i_ctrl,
    input  logic [spq_pkg::ID_W-1:0] i_pid,
    input  logic [PRIO_BITS-1:0]     i_prio,
    input  logic [spq_pkg::ID_W-1:0] i_left_id,
    input  logic [PRIO_BITS-1:0]     i_left_prio,
    input  logic                     i_left_valid,
    input  logic                     i_left_ins,
    input  logic [spq_pkg::ID_W-1:0] i_right_id,
    input  logic [PRIO_BITS-1:0]     i_right_prio,
    input  logic                     i_right_valid,
    input  logic                     i_found,
    output logic [spq_pkg::ID_W-1:0] o_id,
    output logic [PRIO_BITS-1:0]     o_prio,
    output logic                     o_valid,
    output logic                     o_ins,
    output logic                     o_found,
    output logic                     o_hit
);
    import spq_pkg::*;

    logic [ID_W-1:0]      r_id;
    logic [PRIO_BITS-1:0] r_prio;
    logic                 r_valid;
    logic                 w_match;
    logic                 w_del;

    assign o_id    = r_id;
    assign o_prio  = r_prio;
    assign o_valid = r_valid;

    assign o_ins   = !r_valid || (i_prio > r_prio);
    assign w_match = r_valid && (r_id == i_pid);
    assign o_found = i_found || w_match;
    assign o_hit   = w_match && !i_found;
    assign w_del   = i_ctrl.pop_en || (i_ctrl.rem_en && o_found);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctrl.ins_en && o_ins) begin
            if (i_left_ins) begin
                r_valid <= i_left_valid;
            end else begin
                r_valid <= 1'b1;
            end
        end else if (w_del) begin
            r_valid <= i_right_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.ins_en && o_ins) begin
            if (i_left_ins) begin
                r_id   <= i_left_id;
                r_prio <= i_left_prio;
            end else begin
                r_id   <= i_pid;
                r_prio <= i_prio;
            end
        end else if (w_del) begin
            r_id   <= i_right_id;
            r_prio <= i_right_prio;
        end
    end

endmodule

@@ hdl/spq_checker.sv @@
`timescale 1ns / 1ps

module spq_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         start,
    input logic                         busy,
    input logic [1:0]                   i_mode,
    input logic                         o_done,
    input logic [spq_pkg::STATUS_W-1:0] o_status,
    input logic [spq_pkg::ID_W-1:0]     o_result_id,
    input logic [spq_pkg::PRIO_W-1:0]   o_result_priority
);
    import spq_pkg::*;

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted word did not raise busy");

    a_busy_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> o_done && !busy)
        else $error("result did not follow the update cycle");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_status == ST_OK || o_status == ST_MISS || o_status == ST_FULL))
        else $error("undefined status code");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_status != ST_OK |-> o_result_id == '0 && o_result_priority == '0)
        else $error("failed result carries nonzero payload");

    a_full_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_status == ST_FULL |-> $past(i_mode, 2) == MODE_INSERT)
        else $error("full status on a non-insert word");

endmodule

bind stable_priority_process_queue spq_checker u_spq_checker (.*);
